FILE: rtl/wrip_pkg.sv
`default_nettype none

package wrip_pkg;

  localparam int WEIGHT_W = 16;
  localparam int WORD_W   = 31;
  localparam int TOTAL_W  = 24;
  localparam int INDEX_W  = 8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_PICK   = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [WEIGHT_W-1:0] weight;
    logic [WORD_W-1:0]   random_word;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] picked_index;
    logic               empty_error;
  } out_item_t;

  // one slot of the remainder chain
  typedef struct packed {
    logic               valid;
    logic [TOTAL_W-1:0] rem;
    logic [WORD_W-1:0]  word;
    logic [TOTAL_W-1:0] divisor;
  } mod_stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SRCH,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/wrip_ram.sv
`default_nettype none

module wrip_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wrip_mod_cell.sv
`default_nettype none

module wrip_mod_cell
  import wrip_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire mod_stage_t stage_i,
  output mod_stage_t      stage_o
);

  logic                 valid_r;
  logic [TOTAL_W-1:0]   rem_r;
  logic [WORD_W-1:0]    word_r;
  logic [TOTAL_W-1:0]   divisor_r;
  logic [TOTAL_W:0]     trial;
  logic [TOTAL_W:0]     diff;
  logic [TOTAL_W-1:0]   rem_nxt;

  // one restoring step: bring in the next word bit, subtract if it fits
  always_comb begin
    trial = {stage_i.rem, stage_i.word[WORD_W-1]};
    diff  = trial - {1'b0, stage_i.divisor};
    if (trial >= {1'b0, stage_i.divisor}) begin
      rem_nxt = diff[TOTAL_W-1:0];
    end else begin
      rem_nxt = trial[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stage_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    word_r    <= {stage_i.word[WORD_W-2:0], 1'b0};
    divisor_r <= stage_i.divisor;
  end

  assign stage_o = '{valid: valid_r, rem: rem_r, word: word_r, divisor: divisor_r};

endmodule

`default_nettype wire

FILE: rtl/weighted_random_index_pick.sv
`default_nettype none

// channel  direction  payload     fields
// in_      input      in_item_t   action, weight, random_word
// out_     output     out_item_t  picked_index, empty_error
//
// clear, append and unused codes give no result. a pick with no entries
// skips to an empty_error result; any other pick runs the word through a
// 31-cell remainder chain (one cell per word bit), then a lower-bound
// search over the prefix memory, each halving step a search state that
// issues the registered read followed by a compare state.
// rst_n is synchronous; the prefix memory is not cleared, only the count and the total.
// a finished result waits in the output register while out_ready is low;
// the next request is taken once the pick has moved into that register.

module weighted_random_index_pick
  import wrip_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}} :
                                          WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] target_r, target_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   mid_r, mid_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  logic               fin_load;
  logic [WEIGHT_W-1:0] weight_used;
  logic [TOTAL_W:0]   sum;
  logic               append_ok;
  logic [CNT_W-1:0]   mid;
  logic [31:0]        lo_ext;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [TOTAL_W-1:0] ram_rdata;

  mod_stage_t         link [WORD_W+1];

  // remainder chain
  assign link[0] = '{valid:   accept && (in_data.action == ACT_PICK) && (count_r != '0),
                     rem:     '0,
                     word:    in_data.random_word,
                     divisor: total_r};

  for (genvar g = 0; g < WORD_W; g++) begin : g_cell
    wrip_mod_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (link[g]),
      .stage_o (link[g+1])
    );
  end

  wrip_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_prefix_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (sum[TOTAL_W-1:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (mid[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign weight_used = in_data.weight & WMASK;
  assign sum         = {1'b0, total_r} + (TOTAL_W+1)'(weight_used);
  assign append_ok   = (weight_used != '0) && (count_r < CNT_W'(MAX_ENTRIES)) && !sum[TOTAL_W];
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_ext      = 32'(lo_r);

  // control outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    accept    = in_valid && in_ready;
    fin_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    ram_rd_en = (state_r == ST_SRCH) && (lo_r != hi_r);
    ram_wr_en = accept && (in_data.action == ACT_APPEND) && append_ok;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.action == ACT_PICK)) begin
          state_nxt = (count_r == '0) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (link[WORD_W].valid) begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        state_nxt = (lo_r == hi_r) ? ST_FIN : ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_SRCH;
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    target_nxt = target_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    err_nxt    = err_r;
    if (accept) begin
      case (in_data.action)
        ACT_CLEAR: begin
          count_nxt = '0;
          total_nxt = '0;
        end
        ACT_APPEND: begin
          if (append_ok) begin
            total_nxt = sum[TOTAL_W-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
        ACT_PICK: begin
          err_nxt = (count_r == '0);
          lo_nxt  = '0;
          hi_nxt  = count_r;
        end
        default: begin
        end
      endcase
    end
    if ((state_r == ST_DIV) && link[WORD_W].valid) begin
      target_nxt = link[WORD_W].rem + 1'b1;
    end
    if (state_r == ST_SRCH) begin
      mid_nxt = mid;
    end
    // lower bound: entries below the target push lo past mid
    if (state_r == ST_CMP) begin
      if (ram_rdata < target_r) begin
        lo_nxt = mid_r + 1'b1;
      end else begin
        hi_nxt = mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    err_r    <= err_nxt;
    if (fin_load) begin
      out_data_r.picked_index <= err_r ? '0 : lo_ext[INDEX_W-1:0];
      out_data_r.empty_error  <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count past capacity");

  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (mid_r < count_r))
    else $error("search read beyond filled entries");

  a_chain_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    link[WORD_W].valid |-> (state_r == ST_DIV))
    else $error("remainder left the chain outside a pick");

  a_error_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.empty_error) |-> (out_data.picked_index == '0))
    else $error("empty pick with nonzero index");

endmodule

`default_nettype wire
